/* rtl/ultrasonic_ranging_median_filter_core_assert.svh */
// assertion macros shared by the rtl
`ifndef ULTRASONIC_RANGING_MEDIAN_FILTER_CORE_ASSERT_SVH
`define ULTRASONIC_RANGING_MEDIAN_FILTER_CORE_ASSERT_SVH

// same-cycle implication
`define URMF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define URMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/urmf_pkg.sv */
package urmf_pkg;

  localparam int FRACTION_BITS_DEF = 4;
  localparam int MEDIAN_DEPTH      = 3;

  localparam int PULSE_W = 16;
  localparam int SPEED_W = 22;
  localparam int DIST_W  = 14;
  localparam int IVAL_W  = 16;
  localparam int TEMP_W  = 11;
  localparam int CFG_W   = 16;

  localparam int SPEED_BASE    = 3313000;
  localparam int SPEED_SLOPE   = 606;
  localparam int RANGE_DIVISOR = 20000000;

  localparam logic [IVAL_W-1:0] IVAL_RST  = 16'd100;
  localparam logic [TEMP_W-1:0] TEMP_RST  = 11'd220;
  localparam logic [DIST_W-1:0] RANGE_RST = 14'd4000;

  localparam logic [1:0] REQ_TICK    = 2'd0;
  localparam logic [1:0] REQ_ECHO    = 2'd1;
  localparam logic [1:0] REQ_TIMEOUT = 2'd2;

  localparam logic [1:0] CFG_INTERVAL_MS  = 2'd0;
  localparam logic [1:0] CFG_TEMPERATURE  = 2'd1;
  localparam logic [1:0] CFG_MAX_RANGE_MM = 2'd2;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MUL   = 7'b0000010,
    ST_PREP  = 7'b0000100,
    ST_DIV   = 7'b0001000,
    ST_CHECK = 7'b0010000,
    ST_MED   = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

endpackage

/* rtl/ultrasonic_ranging_median_filter_core.sv */
// channel  | ports                                          | direction
// input    | in_valid, in_stall, in_req_type, in_pulse_us   | in (stall out)
// result   | out_valid, out_stall, out_start_trigger,       | out (stall in)
//          | out_busy_res, out_distance_mm, out_distance_valid |
// config   | cfg_we, cfg_index, cfg_wdata                   | in
//
// tick, timeout and unknown transactions: from accept to the done state, then the result register
// echo: multiply, prep, divide and check states, then a median state when the ring is full, then done;
//   the multiplier is a 16-step shift-add, the divider a restoring one giving one quotient bit per cycle
// one transaction in work at a time; in_stall is high until the result is registered
// a result waiting under out_stall does not block the next accept
// synchronous active-low reset; no clearing pass after reset
`include "ultrasonic_ranging_median_filter_core_assert.svh"

module ultrasonic_ranging_median_filter_core #(
  parameter int FRACTION_BITS = urmf_pkg::FRACTION_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_req_type,
  input  logic [urmf_pkg::PULSE_W-1:0] in_pulse_us,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_start_trigger,
  output logic                        out_busy_res,
  output logic [urmf_pkg::DIST_W-1:0] out_distance_mm,
  output logic                        out_distance_valid,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [urmf_pkg::CFG_W-1:0]  cfg_wdata
);

  localparam int SW      = urmf_pkg::DIST_W + FRACTION_BITS;
  localparam int QW      = SW + 1;
  localparam int PW      = urmf_pkg::PULSE_W + urmf_pkg::SPEED_W;
  localparam int DIVISOR = urmf_pkg::RANGE_DIVISOR >> FRACTION_BITS;
  localparam int DW      = $clog2(DIVISOR + 1);
  localparam int HW      = PW - QW;
  localparam int XW      = (HW > DW) ? HW : DW;
  localparam int NMAX    = (QW > urmf_pkg::PULSE_W) ? QW : urmf_pkg::PULSE_W;
  localparam int CW      = $clog2(NMAX);
  localparam int PMSB    = urmf_pkg::PULSE_W - 1;

  logic [urmf_pkg::IVAL_W-1:0]        ival_r;
  logic signed [urmf_pkg::TEMP_W-1:0] temp_r;
  logic [urmf_pkg::DIST_W-1:0]        maxr_r;

  urmf_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic [urmf_pkg::IVAL_W-1:0]   tick_r, tick_nxt;
  logic                          busy_r, busy_nxt;
  logic                          trig_r, trig_nxt;
  logic [1:0]                    ptr_r, ptr_nxt;
  logic [1:0]                    fill_r, fill_nxt;
  logic [SW-1:0]                 held_r, held_nxt;
  logic                          hvalid_r, hvalid_nxt;
  logic [PW-1:0]                 acc_r, acc_nxt;
  logic [urmf_pkg::PULSE_W-1:0]  pls_r, pls_nxt;
  logic [urmf_pkg::SPEED_W-1:0]  spd_r, spd_nxt;
  logic [QW-1:0]                 dq_r, dq_nxt;
  logic [DW-1:0]                 rem_r, rem_nxt;
  logic                          ovf_r, ovf_nxt;
  logic [SW-1:0]                 ring_r [urmf_pkg::MEDIAN_DEPTH];
  logic                          ring_we;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_trig_r, out_busy_r, out_dvalid_r;
  logic [urmf_pkg::DIST_W-1:0]   out_dist_r;
  logic                          out_load;

  logic signed [23:0]            speed_full;
  logic [urmf_pkg::IVAL_W-1:0]   tick_inc;
  logic [XW-1:0]                 hi_x;
  logic [DW:0]                   part;
  logic                          part_ge;
  logic [DW:0]                   part_diff;
  logic [QW-1:0]                 rng_lim;
  logic                          reject;
  logic                          ab, ac, bc;
  logic [SW-1:0]                 med;

  assign in_stall           = (state_r != urmf_pkg::ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_start_trigger  = out_trig_r;
  assign out_busy_res       = out_busy_r;
  assign out_distance_mm    = out_dist_r;
  assign out_distance_valid = out_dvalid_r;

  assign speed_full = 24'(urmf_pkg::SPEED_BASE) + 24'(temp_r) * 24'(urmf_pkg::SPEED_SLOPE);
  assign tick_inc   = tick_r + 16'd1;
  assign hi_x       = XW'(acc_r[PW-1:QW]);
  assign part       = {rem_r, dq_r[QW-1]};
  assign part_ge    = (part >= (DW+1)'(DIVISOR));
  assign part_diff  = part - (DW+1)'(DIVISOR);
  assign rng_lim    = QW'(maxr_r) << FRACTION_BITS;
  assign reject     = ovf_r || (dq_r > rng_lim) || ((dq_r == rng_lim) && (rem_r != '0));
  assign out_load   = (state_r == urmf_pkg::ST_DONE) && (!out_valid_r || !out_stall);

  // median of three
  assign ab  = ring_r[0] > ring_r[1];
  assign ac  = ring_r[0] > ring_r[2];
  assign bc  = ring_r[1] > ring_r[2];
  assign med = (ab != ac) ? ring_r[0] : ((ab == bc) ? ring_r[1] : ring_r[2]);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    tick_nxt   = tick_r;
    busy_nxt   = busy_r;
    trig_nxt   = trig_r;
    ptr_nxt    = ptr_r;
    fill_nxt   = fill_r;
    held_nxt   = held_r;
    hvalid_nxt = hvalid_r;
    acc_nxt    = acc_r;
    pls_nxt    = pls_r;
    spd_nxt    = spd_r;
    dq_nxt     = dq_r;
    rem_nxt    = rem_r;
    ovf_nxt    = ovf_r;
    ring_we    = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      urmf_pkg::ST_IDLE: begin
        if (in_valid) begin
          trig_nxt  = 1'b0;
          state_nxt = urmf_pkg::ST_DONE;
          unique case (in_req_type)
            urmf_pkg::REQ_TICK: begin
              tick_nxt = tick_inc;
              if (tick_inc >= ival_r) begin
                tick_nxt = '0;
                if (!busy_r) begin
                  trig_nxt = 1'b1;
                  busy_nxt = 1'b1;
                end
              end
            end
            urmf_pkg::REQ_ECHO: begin
              busy_nxt  = 1'b0;
              acc_nxt   = '0;
              pls_nxt   = in_pulse_us;
              spd_nxt   = speed_full[urmf_pkg::SPEED_W-1:0];
              cnt_nxt   = CW'(urmf_pkg::PULSE_W - 1);
              state_nxt = urmf_pkg::ST_MUL;
            end
            urmf_pkg::REQ_TIMEOUT: begin
              if (busy_r) begin
                busy_nxt   = 1'b0;
                held_nxt   = '0;
                hvalid_nxt = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      urmf_pkg::ST_MUL: begin
        acc_nxt = (acc_r << 1) + (pls_r[PMSB] ? PW'(spd_r) : '0);
        pls_nxt = pls_r << 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = urmf_pkg::ST_PREP;
        end
      end
      urmf_pkg::ST_PREP: begin
        ovf_nxt   = (hi_x >= XW'(DIVISOR));
        rem_nxt   = DW'(hi_x);
        dq_nxt    = acc_r[QW-1:0];
        cnt_nxt   = CW'(QW - 1);
        state_nxt = urmf_pkg::ST_DIV;
      end
      urmf_pkg::ST_DIV: begin
        rem_nxt = part_ge ? part_diff[DW-1:0] : part[DW-1:0];
        dq_nxt  = {dq_r[QW-2:0], part_ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = urmf_pkg::ST_CHECK;
        end
      end
      urmf_pkg::ST_CHECK: begin
        state_nxt = urmf_pkg::ST_DONE;
        if (reject) begin
          held_nxt   = '0;
          hvalid_nxt = 1'b0;
          fill_nxt   = '0;
        end else begin
          ring_we = 1'b1;
          ptr_nxt = (ptr_r == 2'(urmf_pkg::MEDIAN_DEPTH - 1)) ? '0 : ptr_r + 1'b1;
          if (fill_r < 2'(urmf_pkg::MEDIAN_DEPTH)) begin
            fill_nxt = fill_r + 1'b1;
          end
          if (fill_r >= 2'(urmf_pkg::MEDIAN_DEPTH - 1)) begin
            state_nxt = urmf_pkg::ST_MED;
          end
        end
      end
      urmf_pkg::ST_MED: begin
        held_nxt   = med;
        hvalid_nxt = 1'b1;
        state_nxt  = urmf_pkg::ST_DONE;
      end
      urmf_pkg::ST_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = urmf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = urmf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ival_r <= urmf_pkg::IVAL_RST;
      temp_r <= urmf_pkg::TEMP_RST;
      maxr_r <= urmf_pkg::RANGE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        urmf_pkg::CFG_INTERVAL_MS:  ival_r <= cfg_wdata[urmf_pkg::IVAL_W-1:0];
        urmf_pkg::CFG_TEMPERATURE:  temp_r <= cfg_wdata[urmf_pkg::TEMP_W-1:0];
        urmf_pkg::CFG_MAX_RANGE_MM: maxr_r <= cfg_wdata[urmf_pkg::DIST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= urmf_pkg::ST_IDLE;
      cnt_r       <= '0;
      tick_r      <= '0;
      busy_r      <= 1'b0;
      trig_r      <= 1'b0;
      ptr_r       <= '0;
      fill_r      <= '0;
      held_r      <= '0;
      hvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      tick_r      <= tick_nxt;
      busy_r      <= busy_nxt;
      trig_r      <= trig_nxt;
      ptr_r       <= ptr_nxt;
      fill_r      <= fill_nxt;
      held_r      <= held_nxt;
      hvalid_r    <= hvalid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    pls_r <= pls_nxt;
    spd_r <= spd_nxt;
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    ovf_r <= ovf_nxt;
    if (ring_we) begin
      ring_r[ptr_r] <= dq_r[SW-1:0];
    end
    if (out_load) begin
      out_trig_r   <= trig_r;
      out_busy_r   <= busy_r;
      out_dist_r   <= hvalid_r ? urmf_pkg::DIST_W'(held_r >> FRACTION_BITS) : '0;
      out_dvalid_r <= hvalid_r;
    end
  end

  `URMF_ASSERT_NEXT(a_done_loads, out_load, out_valid_r, "result slot not loaded")
  `URMF_ASSERT_NOW(a_held_zero, !hvalid_r, held_r == '0, "held distance nonzero while invalid")
  `URMF_ASSERT_NOW(a_trig_busy, out_valid_r && out_trig_r, out_busy_r,
    "trigger without busy")
  `URMF_ASSERT_NOW(a_ptr_range, 1'b1, ptr_r != 2'd3, "ring pointer out of range")
  `URMF_ASSERT_NEXT(a_div_end, (state_r == urmf_pkg::ST_DIV) && (cnt_r == '0),
    state_r == urmf_pkg::ST_CHECK, "divider did not finish")

endmodule

/* tb/ultrasonic_ranging_median_filter_core_tb.sv */
module ultrasonic_ranging_median_filter_core_tb;

  localparam int FB = urmf_pkg::FRACTION_BITS_DEF;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam bit ROW_ITEM = 1'b0;
  localparam bit ROW_REG = 1'b1;
  localparam bit PRED = 1'b0;
  localparam bit TYPED = 1'b1;

  typedef struct packed {
    logic                        trig;
    logic                        busy;
    logic [urmf_pkg::DIST_W-1:0] dmm;
    logic                        dv;
  } reading_t;

  typedef struct packed {
    bit       is_reg;
    logic [1:0]  code;
    logic [15:0] data;
    bit          typed;
    reading_t    want;
  } script_row_t;

  typedef struct {
    bit       typed;
    reading_t want;
  } row_tag_t;

  localparam reading_t ZERO = '0;
  localparam reading_t BUSY_ONLY = '{1'b0, 1'b1, '0, 1'b0};
  localparam reading_t FIRED = '{1'b1, 1'b1, '0, 1'b0};

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_req_type = urmf_pkg::REQ_TICK;
  logic [urmf_pkg::PULSE_W-1:0] in_pulse_us = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_start_trigger;
  logic              out_busy_res;
  logic [urmf_pkg::DIST_W-1:0] out_distance_mm;
  logic              out_distance_valid;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_index = urmf_pkg::CFG_INTERVAL_MS;
  logic [urmf_pkg::CFG_W-1:0]  cfg_wdata = '0;

  // predictor copy of registers and state
  logic [urmf_pkg::IVAL_W-1:0]        ival_r;
  logic signed [urmf_pkg::TEMP_W-1:0] temp_r;
  logic [urmf_pkg::DIST_W-1:0]        range_r;
  logic [15:0]              ticks;
  bit                       busy;
  logic [17:0]              ring [urmf_pkg::MEDIAN_DEPTH];
  int unsigned              ring_ptr;
  int unsigned              fill;
  logic [17:0]              held_d;
  bit                       held_v;

  reading_t readings_due [$];
  row_tag_t row_tags [$];
  int mismatches = 0;
  int n_items = 0, n_fired = 0, n_medians = 0, n_rejects = 0, n_timeouts = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  script_row_t script [$] = '{
    '{ROW_ITEM, urmf_pkg::REQ_TIMEOUT, 16'd0, TYPED, ZERO},
    '{ROW_ITEM, REQ_UNKNOWN, 16'hFFFF, TYPED, ZERO},
    '{ROW_ITEM, urmf_pkg::REQ_ECHO, 16'd0, TYPED, ZERO},
    '{ROW_ITEM, urmf_pkg::REQ_ECHO, 16'hFFFF, TYPED, ZERO},
    '{ROW_REG, urmf_pkg::CFG_INTERVAL_MS, 16'd1, PRED, ZERO},
    '{ROW_ITEM, urmf_pkg::REQ_TICK, 16'd0, TYPED, FIRED},
    '{ROW_ITEM, urmf_pkg::REQ_TICK, 16'hAAAA, TYPED, BUSY_ONLY},
    '{ROW_ITEM, REQ_UNKNOWN, 16'd0, TYPED, BUSY_ONLY},
    '{ROW_ITEM, urmf_pkg::REQ_TIMEOUT, 16'd0, TYPED, ZERO},
    '{ROW_ITEM, urmf_pkg::REQ_TICK, 16'h5555, TYPED, FIRED},
    '{ROW_ITEM, urmf_pkg::REQ_ECHO, 16'd5000, PRED, ZERO},
    '{ROW_ITEM, urmf_pkg::REQ_ECHO, 16'd10000, PRED, ZERO},
    '{ROW_ITEM, urmf_pkg::REQ_ECHO, 16'd20000, PRED, ZERO},
    '{ROW_ITEM, urmf_pkg::REQ_ECHO, 16'd15000, PRED, ZERO},
    '{ROW_REG, urmf_pkg::CFG_TEMPERATURE, 16'h0400, PRED, ZERO},
    '{ROW_REG, urmf_pkg::CFG_MAX_RANGE_MM, 16'hFFFF, PRED, ZERO},
    '{ROW_ITEM, urmf_pkg::REQ_ECHO, 16'hFFFF, PRED, ZERO},
    '{ROW_ITEM, urmf_pkg::REQ_ECHO, 16'd1, PRED, ZERO},
    '{ROW_REG, urmf_pkg::CFG_TEMPERATURE, 16'h03FF, PRED, ZERO},
    '{ROW_REG, urmf_pkg::CFG_INTERVAL_MS, 16'd0, PRED, ZERO},
    '{ROW_ITEM, urmf_pkg::REQ_TICK, 16'd0, PRED, ZERO},
    '{ROW_ITEM, urmf_pkg::REQ_ECHO, 16'hFFFF, PRED, ZERO},
    '{ROW_ITEM, urmf_pkg::REQ_TIMEOUT, 16'd0, PRED, ZERO},
    '{ROW_REG, urmf_pkg::CFG_MAX_RANGE_MM, 16'd0, PRED, ZERO},
    '{ROW_ITEM, urmf_pkg::REQ_ECHO, 16'd0, PRED, ZERO},
    '{ROW_ITEM, urmf_pkg::REQ_ECHO, 16'd1, TYPED, ZERO},
    '{ROW_REG, urmf_pkg::CFG_INTERVAL_MS, 16'hFFFF, PRED, ZERO},
    '{ROW_REG, urmf_pkg::CFG_TEMPERATURE, 16'hFE70, PRED, ZERO},
    '{ROW_REG, urmf_pkg::CFG_MAX_RANGE_MM, 16'd4000, PRED, ZERO},
    '{ROW_ITEM, urmf_pkg::REQ_TICK, 16'd0, PRED, ZERO},
    '{ROW_ITEM, urmf_pkg::REQ_ECHO, 16'd23000, PRED, ZERO},
    '{ROW_REG, urmf_pkg::CFG_TEMPERATURE, 16'd850, PRED, ZERO},
    '{ROW_ITEM, urmf_pkg::REQ_ECHO, 16'd23000, PRED, ZERO}
  };

  ultrasonic_ranging_median_filter_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_pulse_us       (in_pulse_us),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_start_trigger (out_start_trigger),
    .out_busy_res      (out_busy_res),
    .out_distance_mm   (out_distance_mm),
    .out_distance_valid(out_distance_valid),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic logic [17:0] mid_of_three(logic [17:0] a, logic [17:0] b, logic [17:0] c);
    logic [17:0] lo, hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return (c < lo) ? lo : (c > hi) ? hi : c;
  endfunction

  function automatic longint speed_now();
    return longint'(urmf_pkg::SPEED_BASE) + longint'(urmf_pkg::SPEED_SLOPE) * longint'(temp_r);
  endfunction

  function automatic reading_t predict_ranging(logic [1:0] kind, logic [15:0] pulse);
    reading_t r;
    longint unsigned prod;
    r = '0;
    case (kind)
      urmf_pkg::REQ_TICK: begin
        ticks = ticks + 16'd1;
        if (ticks >= ival_r) begin
          ticks = '0;
          if (!busy) begin
            r.trig = 1'b1;
            busy = 1'b1;
            n_fired++;
          end
        end
      end
      urmf_pkg::REQ_ECHO: begin
        prod = longint'(pulse) * speed_now();
        busy = 1'b0;
        if (prod > longint'(range_r) * longint'(urmf_pkg::RANGE_DIVISOR)) begin
          held_d = '0;
          held_v = 1'b0;
          fill = 0;
          n_rejects++;
        end else begin
          ring[ring_ptr] = 18'((prod << FB) / longint'(urmf_pkg::RANGE_DIVISOR));
          ring_ptr = (ring_ptr + 1) % urmf_pkg::MEDIAN_DEPTH;
          if (fill < urmf_pkg::MEDIAN_DEPTH) fill++;
          if (fill >= urmf_pkg::MEDIAN_DEPTH) begin
            held_d = mid_of_three(ring[0], ring[1], ring[2]);
            held_v = 1'b1;
            n_medians++;
          end
        end
      end
      urmf_pkg::REQ_TIMEOUT: begin
        if (busy) begin
          busy = 1'b0;
          held_d = '0;
          held_v = 1'b0;
          n_timeouts++;
        end
      end
      default: ;
    endcase
    r.busy = busy;
    r.dmm = held_v ? urmf_pkg::DIST_W'(held_d >> FB) : '0;
    r.dv = held_v;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [15:0] want, input logic [15:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s at %0t: expected %0d, got %0d", what, $realtime, want, got);
  endtask

  // accepted transactions feed the predictor
  always @(posedge clk) begin
    row_tag_t tag;
    reading_t r;
    if (rst_n && in_valid && !in_stall) begin
      tag = row_tags.pop_front();
      r = predict_ranging(in_req_type, in_pulse_us);
      readings_due.push_back(tag.typed ? tag.want : r);
      n_items++;
    end
  end

  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (readings_due.size() == 0) begin
        flag_mismatch("result with none outstanding", 'x, out_distance_mm);
      end else begin
        want = readings_due.pop_front();
        if (out_start_trigger !== want.trig)
          flag_mismatch("start_trigger", want.trig, out_start_trigger);
        if (out_busy_res !== want.busy)
          flag_mismatch("busy_res", want.busy, out_busy_res);
        if (out_distance_mm !== want.dmm)
          flag_mismatch("distance_mm", want.dmm, out_distance_mm);
        if (out_distance_valid !== want.dv)
          flag_mismatch("distance_valid", want.dv, out_distance_valid);
      end
    end
  end

  // receiver, with an occasional long hold-off
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 9);
    end
  end

  task automatic send_item(input logic [1:0] kind, input logic [15:0] pulse, input bit typed,
                           input reading_t want);
    row_tag_t tag;
    tag.typed = typed;
    tag.want = want;
    while (!calm && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    row_tags.push_back(tag);
    in_valid <= 1'b1;
    in_req_type <= kind;
    in_pulse_us <= pulse;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (readings_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      urmf_pkg::CFG_INTERVAL_MS:  ival_r = val;
      urmf_pkg::CFG_TEMPERATURE:  temp_r = val[urmf_pkg::TEMP_W-1:0];
      urmf_pkg::CFG_MAX_RANGE_MM: range_r = val[urmf_pkg::DIST_W-1:0];
      default: ;
    endcase
  endtask

  // mostly tick runs up to the interval, then an echo or a timeout
  task automatic run_phase(input int target);
    int sent, nt, pick;
    longint lim, edge_pw;
    logic [15:0] pw;
    logic [1:0] kind;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(99) < 80) begin
        nt = (ival_r == 0) ? 1 : (ival_r > 12) ? $urandom_range(1, 4) : int'(ival_r);
        if ($urandom_range(9) == 0) nt++;
        repeat (nt) send_item(urmf_pkg::REQ_TICK, 16'($urandom), PRED, ZERO);
        if ($urandom_range(99) < 85) begin
          lim = (longint'(range_r) * longint'(urmf_pkg::RANGE_DIVISOR)) / speed_now();
          pick = $urandom_range(99);
          if (pick < 70) begin
            pw = (lim >= 65535) ? 16'($urandom) : 16'($urandom_range(0, int'(lim)));
          end else if (pick < 85) begin
            edge_pw = lim + longint'($urandom_range(0, 2)) - 1;
            pw = (edge_pw < 0) ? 16'd0 : (edge_pw > 65535) ? 16'hFFFF : 16'(edge_pw);
          end else begin
            pw = 16'($urandom);
          end
          send_item(urmf_pkg::REQ_ECHO, pw, PRED, ZERO);
        end else begin
          send_item(urmf_pkg::REQ_TIMEOUT, 16'($urandom), PRED, ZERO);
        end
        sent += nt + 1;
      end else begin
        kind = 2'($urandom);
        send_item(kind, 16'($urandom), PRED, ZERO);
        if (kind != REQ_UNKNOWN) sent++;
      end
    end
  endtask

  initial begin
    ival_r = urmf_pkg::IVAL_RST;
    temp_r = urmf_pkg::TEMP_RST;
    range_r = urmf_pkg::RANGE_RST;
    ticks = '0;
    busy = 1'b0;
    foreach (ring[i]) ring[i] = '0;
    ring_ptr = 0;
    fill = 0;
    held_d = '0;
    held_v = 1'b0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].is_reg) begin
        settle();
        write_reg(script[i].code, script[i].data);
      end else begin
        send_item(script[i].code, script[i].data, script[i].typed, script[i].want);
      end
    end

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      calm = (ph == 0);
      case (ph)
        0: begin
          write_reg(urmf_pkg::CFG_INTERVAL_MS, 16'd1);
          write_reg(urmf_pkg::CFG_TEMPERATURE, 16'd220);
          write_reg(urmf_pkg::CFG_MAX_RANGE_MM, 16'd4000);
        end
        1: begin
          write_reg(urmf_pkg::CFG_INTERVAL_MS, 16'($urandom_range(1, 6)));
          write_reg(urmf_pkg::CFG_TEMPERATURE, 16'hFE70);
          write_reg(urmf_pkg::CFG_MAX_RANGE_MM, 16'd16383);
          hold_req = 1'b1;
        end
        2: begin
          write_reg(urmf_pkg::CFG_INTERVAL_MS, 16'd2);
          write_reg(urmf_pkg::CFG_TEMPERATURE, 16'd850);
          write_reg(urmf_pkg::CFG_MAX_RANGE_MM, 16'($urandom_range(100, 3000)));
        end
        3: begin
          write_reg(urmf_pkg::CFG_INTERVAL_MS, 16'd0);
          write_reg(urmf_pkg::CFG_TEMPERATURE, 16'($urandom));
          write_reg(urmf_pkg::CFG_MAX_RANGE_MM, 16'($urandom_range(0, 16383)));
        end
        4: begin
          write_reg(urmf_pkg::CFG_INTERVAL_MS, 16'd3);
          write_reg(urmf_pkg::CFG_TEMPERATURE, 16'($urandom_range(0, 1250)) - 16'd400);
          write_reg(urmf_pkg::CFG_MAX_RANGE_MM, 16'd16383);
        end
        default: begin
          write_reg(urmf_pkg::CFG_INTERVAL_MS, 16'($urandom_range(1, 12)));
          write_reg(urmf_pkg::CFG_TEMPERATURE, 16'd220);
          write_reg(urmf_pkg::CFG_MAX_RANGE_MM, 16'($urandom_range(500, 8000)));
        end
      endcase
      run_phase(140);
    end

    settle();
    repeat (60) @(posedge clk);
    if (readings_due.size() != 0)
      flag_mismatch("results never delivered", 16'(readings_due.size()), 16'd0);
    $display("covered %0d transactions under directed and six random register settings",
             n_items);
    $display("%0d trigger requests, %0d median readings, %0d rejected echoes, %0d timeouts",
             n_fired, n_medians, n_rejects, n_timeouts);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout waiting for the block");
    $display("Mismatches found");
    $finish;
  end

endmodule
